// ----- rtl/dhbm_pkg.sv -----
// dhbm_pkg: shared types and codes for the depth histogram band mean unit
// holds controller states, result status codes, register indexes and the
// command/status structs between controller and datapath; no dependencies
`timescale 1ns / 1ps

package dhbm_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_THRESHOLD = 4'd1;

    localparam logic [CFG_DATA_W-1:0] MIN_VALID_RST     = 9'd128;
    localparam logic [CFG_DATA_W-1:0] BIN_THRESHOLD_RST = 9'd64;

    // fixed field widths
    localparam int DEPTH_W  = 16;
    localparam int BAND_W   = 4;
    localparam int COUNT_W  = 9;
    localparam int RECIP_W  = 18;
    localparam int PROD_W   = DEPTH_W + RECIP_W;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_VALID   = 2'd1,
        ST_FEW_VALID  = 2'd2,
        ST_EMPTY_BAND = 2'd3
    } status_t;

    // controller states
    typedef enum logic [3:0] {
        S_LOAD,
        S_BIN,
        S_CHECK,
        S_SEARCH,
        S_BOUND,
        S_SCAN,
        S_DIV,
        S_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic update;
        logic check;
        logic search;
        logic bound;
        logic scan;
        logic div_step;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_flag;
        logic no_valid;
        logic few_valid;
        logic bin_hit;
        logic srch_last;
        logic scan_done;
        logic cnt_zero;
        logic div_done;
        logic res_free;
    } sts_t;

endpackage

// ----- rtl/dhbm_ctrl.sv -----
// dhbm_ctrl: sequencing state machine for the depth histogram band mean unit
// walks load, histogram update, band search, band scan and divide phases
// depends on dhbm_pkg
`timescale 1ns / 1ps

module dhbm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pix_valid,
    output logic           pix_stall,
    input  dhbm_pkg::sts_t sts,
    output dhbm_pkg::cmd_t cmd
);

    dhbm_pkg::state_t state_reg;
    dhbm_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dhbm_pkg::S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dhbm_pkg::S_LOAD:
            begin
                if (pix_valid)
                begin
                    state_next = dhbm_pkg::S_BIN;
                end
            end
            dhbm_pkg::S_BIN:
            begin
                state_next = sts.last_flag ? dhbm_pkg::S_CHECK : dhbm_pkg::S_LOAD;
            end
            dhbm_pkg::S_CHECK:
            begin
                if (sts.no_valid || sts.few_valid)
                begin
                    state_next = dhbm_pkg::S_EMIT;
                end
                else
                begin
                    state_next = dhbm_pkg::S_SEARCH;
                end
            end
            dhbm_pkg::S_SEARCH:
            begin
                if (sts.bin_hit || sts.srch_last)
                begin
                    state_next = dhbm_pkg::S_BOUND;
                end
            end
            dhbm_pkg::S_BOUND:
            begin
                state_next = dhbm_pkg::S_SCAN;
            end
            dhbm_pkg::S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = sts.cnt_zero ? dhbm_pkg::S_EMIT : dhbm_pkg::S_DIV;
                end
            end
            dhbm_pkg::S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = dhbm_pkg::S_EMIT;
                end
            end
            dhbm_pkg::S_EMIT:
            begin
                if (sts.res_free)
                begin
                    state_next = dhbm_pkg::S_LOAD;
                end
            end
            default:
            begin
                state_next = dhbm_pkg::S_LOAD;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd       = '0;
        pix_stall = 1'b1;
        unique case (state_reg)
            dhbm_pkg::S_LOAD:
            begin
                pix_stall   = 1'b0;
                cmd.capture = pix_valid;
            end
            dhbm_pkg::S_BIN:
            begin
                cmd.update = 1'b1;
            end
            dhbm_pkg::S_CHECK:
            begin
                cmd.check = 1'b1;
            end
            dhbm_pkg::S_SEARCH:
            begin
                cmd.search = 1'b1;
            end
            dhbm_pkg::S_BOUND:
            begin
                cmd.bound = 1'b1;
            end
            dhbm_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            dhbm_pkg::S_DIV:
            begin
                cmd.div_step = !sts.div_done;
            end
            dhbm_pkg::S_EMIT:
            begin
                cmd.emit = sts.res_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/dhbm_dpath.sv -----
// dhbm_dpath: pixel store, histogram, band scan accumulator, divider and
// result register of the depth histogram band mean unit
// depends on dhbm_pkg; driven by dhbm_ctrl commands
`timescale 1ns / 1ps

module dhbm_dpath #(
    parameter int BLOCK_PIXELS = 256,
    parameter int BIN_WIDTH    = 500,
    parameter int NUM_BINS     = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dhbm_pkg::cmd_t                    cmd,
    output dhbm_pkg::sts_t                    sts,
    input  logic [dhbm_pkg::DEPTH_W-1:0]      depth_mm,
    input  logic                              last_pixel,
    input  logic [dhbm_pkg::CFG_DATA_W-1:0]   min_valid,
    input  logic [dhbm_pkg::CFG_DATA_W-1:0]   bin_threshold,
    input  logic                              res_stall,
    output logic                              res_valid,
    output logic [dhbm_pkg::DEPTH_W-1:0]      mean_depth_mm,
    output logic [dhbm_pkg::BAND_W-1:0]       band_index,
    output logic [dhbm_pkg::COUNT_W-1:0]      band_count,
    output logic [1:0]                        status
);

    localparam int IDX_W  = (BLOCK_PIXELS > 1) ? $clog2(BLOCK_PIXELS) : 1;
    localparam int CNT_W  = $clog2(BLOCK_PIXELS + 1);
    localparam int BIN_W  = $clog2(NUM_BINS);
    localparam int CMP_W  = (CNT_W > dhbm_pkg::CFG_DATA_W) ? CNT_W : dhbm_pkg::CFG_DATA_W;
    localparam int BND_W  = $clog2(NUM_BINS * BIN_WIDTH + 1);
    localparam int PB_W   = (BND_W > dhbm_pkg::DEPTH_W) ? BND_W : dhbm_pkg::DEPTH_W;
    localparam int SUM_W  = dhbm_pkg::DEPTH_W + CNT_W;
    localparam int DC_W   = $clog2(SUM_W + 1);
    // exact reciprocal for 16-bit dividends: shift 16 + clog2(bin width)
    localparam int SHIFT  = dhbm_pkg::DEPTH_W + $clog2(BIN_WIDTH);
    localparam longint RECIP = ((64'd1 << SHIFT) + BIN_WIDTH - 1) / BIN_WIDTH;

    localparam logic [BIN_W-1:0] TOP_BIN = BIN_W'(NUM_BINS - 1);

    // pixel capture
    logic [dhbm_pkg::DEPTH_W-1:0] depth_reg;
    logic                         last_reg;
    logic [BIN_W-1:0]             bin_reg;

    // block bookkeeping
    logic [CNT_W-1:0] pix_idx_reg;
    logic [CNT_W-1:0] pix_idx_next;
    logic [CNT_W-1:0] valid_cnt_reg;
    logic [CNT_W-1:0] valid_cnt_next;
    logic [CNT_W-1:0] hist_reg  [NUM_BINS];
    logic [CNT_W-1:0] hist_next [NUM_BINS];

    // band search and scan
    logic [BIN_W-1:0]   srch_idx_reg;
    logic [BIN_W-1:0]   band_reg;
    logic [BND_W-1:0]   lo_reg;
    logic [BND_W-1:0]   hi_reg;
    logic [CNT_W-1:0]   scan_idx_reg;
    logic               rd_valid_reg;
    logic [dhbm_pkg::DEPTH_W-1:0] rd_data_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   cnt_reg;
    dhbm_pkg::status_t  code_reg;

    // divider
    logic [SUM_W-1:0] quo_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [DC_W-1:0]  dcnt_reg;

    // result register
    logic                         res_valid_reg;
    logic                         res_valid_next;
    logic [dhbm_pkg::DEPTH_W-1:0] mean_reg;
    logic [dhbm_pkg::BAND_W-1:0]  band_out_reg;
    logic [dhbm_pkg::COUNT_W-1:0] count_out_reg;
    dhbm_pkg::status_t            status_reg;

    // pixel store
    logic [dhbm_pkg::DEPTH_W-1:0] store_mem [BLOCK_PIXELS];

    // combinational helpers
    logic [dhbm_pkg::PROD_W-1:0]  prod;
    logic [dhbm_pkg::DEPTH_W-1:0] quot16;
    logic [BIN_W-1:0]             bin_sat;
    logic                         store_we;
    logic [BIN_W-1:0]             hist_addr;
    logic [CNT_W-1:0]             hist_rd;
    logic                         scan_issue;
    logic [PB_W-1:0]              pix_ext;
    logic                         in_band;
    logic [CNT_W:0]               div_shift;
    logic                         div_ge;
    logic [BND_W-1:0]             lo_calc;
    logic [BIN_W+dhbm_pkg::BAND_W-1:0]  band_ext;
    logic [CNT_W+dhbm_pkg::COUNT_W-1:0] cnt_ext;

    // bin of the incoming pixel by reciprocal multiply, saturated to top bin
    always_comb
    begin
        prod    = dhbm_pkg::PROD_W'(depth_mm) * dhbm_pkg::PROD_W'(RECIP);
        quot16  = dhbm_pkg::DEPTH_W'(prod >> SHIFT);
        bin_sat = (quot16 > dhbm_pkg::DEPTH_W'(NUM_BINS - 1)) ? TOP_BIN
                                                              : quot16[BIN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            depth_reg <= depth_mm;
            last_reg  <= last_pixel;
            bin_reg   <= bin_sat;
        end
    end

    // single histogram read port shared by update and search
    assign hist_addr = cmd.search ? srch_idx_reg : bin_reg;
    assign hist_rd   = hist_reg[hist_addr];
    assign store_we  = cmd.update && (pix_idx_reg < CNT_W'(BLOCK_PIXELS));

    // histogram, valid count and write pointer
    always_comb
    begin
        pix_idx_next   = pix_idx_reg;
        valid_cnt_next = valid_cnt_reg;
        hist_next      = hist_reg;
        if (cmd.emit)
        begin
            pix_idx_next   = '0;
            valid_cnt_next = '0;
            for (int i = 0; i < NUM_BINS; i++)
            begin
                hist_next[i] = '0;
            end
        end
        else if (store_we)
        begin
            pix_idx_next       = pix_idx_reg + 1'b1;
            hist_next[bin_reg] = hist_rd + 1'b1;
            if (depth_reg != '0)
            begin
                valid_cnt_next = valid_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_idx_reg   <= '0;
            valid_cnt_reg <= '0;
            for (int i = 0; i < NUM_BINS; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            pix_idx_reg   <= pix_idx_next;
            valid_cnt_reg <= valid_cnt_next;
            hist_reg      <= hist_next;
        end
    end

    // store write on update, registered read during the scan
    assign scan_issue = cmd.scan && (scan_idx_reg < pix_idx_reg);

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[pix_idx_reg[IDX_W-1:0]] <= depth_reg;
        end
        if (scan_issue)
        begin
            rd_data_reg <= store_mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

    // band bounds and membership test
    assign lo_calc = BND_W'(band_reg) * BND_W'(BIN_WIDTH);
    assign pix_ext = PB_W'(rd_data_reg);
    assign in_band = (pix_ext >= PB_W'(lo_reg)) && (pix_ext <= PB_W'(hi_reg));

    // restoring divider step, one quotient bit per cycle
    assign div_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign div_ge    = div_shift >= {1'b0, cnt_reg};

    // check, search, scan and divide sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            code_reg     <= dhbm_pkg::ST_OK;
            srch_idx_reg <= '0;
            dcnt_reg     <= '0;
        end
        else
        begin
            if (cmd.check)
            begin
                srch_idx_reg <= BIN_W'(1);
                band_reg     <= '0;
                cnt_reg      <= '0;
                sum_reg      <= '0;
                if (valid_cnt_reg == '0)
                begin
                    code_reg <= dhbm_pkg::ST_NO_VALID;
                end
                else if (CMP_W'(valid_cnt_reg) < CMP_W'(min_valid))
                begin
                    code_reg <= dhbm_pkg::ST_FEW_VALID;
                end
                else
                begin
                    code_reg <= dhbm_pkg::ST_OK;
                end
            end

            if (cmd.search)
            begin
                if (sts.bin_hit || sts.srch_last)
                begin
                    band_reg <= srch_idx_reg;
                end
                else
                begin
                    srch_idx_reg <= srch_idx_reg + 1'b1;
                end
            end

            if (cmd.bound)
            begin
                lo_reg       <= lo_calc;
                hi_reg       <= lo_calc + BND_W'(BIN_WIDTH);
                scan_idx_reg <= '0;
                rd_valid_reg <= 1'b0;
            end

            if (cmd.scan)
            begin
                rd_valid_reg <= scan_issue;
                if (scan_issue)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (rd_valid_reg && in_band)
                begin
                    sum_reg <= sum_reg + SUM_W'(rd_data_reg);
                    cnt_reg <= cnt_reg + 1'b1;
                end
                // hand the sum to the divider once the scan drains
                if (sts.scan_done)
                begin
                    quo_reg  <= sum_reg;
                    rem_reg  <= '0;
                    dcnt_reg <= '0;
                    code_reg <= (cnt_reg == '0) ? dhbm_pkg::ST_EMPTY_BAND : dhbm_pkg::ST_OK;
                end
            end

            if (cmd.div_step)
            begin
                quo_reg  <= {quo_reg[SUM_W-2:0], div_ge};
                rem_reg  <= div_ge ? CNT_W'(div_shift - {1'b0, cnt_reg})
                                   : div_shift[CNT_W-1:0];
                dcnt_reg <= dcnt_reg + 1'b1;
            end
        end
    end

    // result register, free once taken
    assign band_ext = {{dhbm_pkg::BAND_W{1'b0}}, band_reg};
    assign cnt_ext  = {{dhbm_pkg::COUNT_W{1'b0}}, cnt_reg};

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            mean_reg      <= (code_reg == dhbm_pkg::ST_OK) ? quo_reg[dhbm_pkg::DEPTH_W-1:0]
                                                           : '0;
            band_out_reg  <= band_ext[dhbm_pkg::BAND_W-1:0];
            count_out_reg <= cnt_ext[dhbm_pkg::COUNT_W-1:0];
            status_reg    <= code_reg;
        end
    end

    // status to controller
    always_comb
    begin
        sts.last_flag = last_reg;
        sts.no_valid  = (valid_cnt_reg == '0);
        sts.few_valid = (CMP_W'(valid_cnt_reg) < CMP_W'(min_valid));
        sts.bin_hit   = (CMP_W'(hist_rd) > CMP_W'(bin_threshold));
        sts.srch_last = (srch_idx_reg == TOP_BIN);
        sts.scan_done = !scan_issue && !rd_valid_reg;
        sts.cnt_zero  = (cnt_reg == '0);
        sts.div_done  = (dcnt_reg == DC_W'(SUM_W));
        sts.res_free  = !res_valid_reg || !res_stall;
    end

    assign res_valid     = res_valid_reg;
    assign mean_depth_mm = mean_reg;
    assign band_index    = band_out_reg;
    assign band_count    = count_out_reg;
    assign status        = status_reg;

endmodule

// ----- rtl/depth_histogram_band_mean_unit.sv -----
// depth_histogram_band_mean_unit: top level, configuration registers and
// wiring of controller and datapath
// depends on dhbm_pkg, dhbm_ctrl, dhbm_dpath
//
//  channel  | signals                                        | handshake
//  ---------+------------------------------------------------+---------------------
//  pixel in | depth_mm, last_pixel                           | pix_valid / pix_stall
//  result   | mean_depth_mm, band_index, band_count, status  | res_valid / res_stall
//  config   | cfg_index, cfg_data                            | cfg_valid / cfg_ready
//
// each pixel is captured with its bin lookup, then stored with its histogram update
// a flagged pixel adds the check, the band search, the bound and the scan of
// the stored pixels, then the divide and the emit; a rejected block goes
// straight to emit, an empty band skips divide
// the result waits in its own register; the next block loads while it is held, and
// only the emit of the following block waits on res_stall; reset spares the pixel store
`timescale 1ns / 1ps

module depth_histogram_band_mean_unit #(
    parameter int BLOCK_PIXELS = 256,
    parameter int BIN_WIDTH    = 500,
    parameter int NUM_BINS     = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pix_valid,
    output logic                              pix_stall,
    input  logic [dhbm_pkg::DEPTH_W-1:0]      depth_mm,
    input  logic                              last_pixel,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [dhbm_pkg::DEPTH_W-1:0]      mean_depth_mm,
    output logic [dhbm_pkg::BAND_W-1:0]       band_index,
    output logic [dhbm_pkg::COUNT_W-1:0]      band_count,
    output logic [1:0]                        status,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dhbm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dhbm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    dhbm_pkg::cmd_t cmd;
    dhbm_pkg::sts_t sts;

    logic [dhbm_pkg::CFG_DATA_W-1:0] min_valid_reg;
    logic [dhbm_pkg::CFG_DATA_W-1:0] min_valid_next;
    logic [dhbm_pkg::CFG_DATA_W-1:0] bin_threshold_reg;
    logic [dhbm_pkg::CFG_DATA_W-1:0] bin_threshold_next;

    assign cfg_ready = 1'b1;

    // register decode, unknown indexes ignored
    always_comb
    begin
        min_valid_next     = min_valid_reg;
        bin_threshold_next = bin_threshold_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                dhbm_pkg::REG_MIN_VALID:     min_valid_next     = cfg_data;
                dhbm_pkg::REG_BIN_THRESHOLD: bin_threshold_next = cfg_data;
                default:
                begin
                    min_valid_next     = min_valid_reg;
                    bin_threshold_next = bin_threshold_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_valid_reg     <= dhbm_pkg::MIN_VALID_RST;
            bin_threshold_reg <= dhbm_pkg::BIN_THRESHOLD_RST;
        end
        else
        begin
            min_valid_reg     <= min_valid_next;
            bin_threshold_reg <= bin_threshold_next;
        end
    end

    // sequencer
    dhbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath
    dhbm_dpath #(
        .BLOCK_PIXELS (BLOCK_PIXELS),
        .BIN_WIDTH    (BIN_WIDTH),
        .NUM_BINS     (NUM_BINS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .depth_mm      (depth_mm),
        .last_pixel    (last_pixel),
        .min_valid     (min_valid_reg),
        .bin_threshold (bin_threshold_reg),
        .res_stall     (res_stall),
        .res_valid     (res_valid),
        .mean_depth_mm (mean_depth_mm),
        .band_index    (band_index),
        .band_count    (band_count),
        .status        (status)
    );

endmodule

// ----- rtl/dhbm_checker.sv -----
// dhbm_port_checks: port-level checks for depth_histogram_band_mean_unit
// attached to the top level by the bind statement at the end of this file
// depends on dhbm_pkg
`timescale 1ns / 1ps

module dhbm_port_checks (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            pix_valid,
    input logic                            pix_stall,
    input logic                            last_pixel,
    input logic                            res_valid,
    input logic                            res_stall,
    input logic [dhbm_pkg::DEPTH_W-1:0]    mean_depth_mm,
    input logic [dhbm_pkg::BAND_W-1:0]     band_index,
    input logic [dhbm_pkg::COUNT_W-1:0]    band_count,
    input logic [1:0]                      status
);

    // a held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(mean_depth_mm)
            && $stable(band_index) && $stable(band_count) && $stable(status))
    else $error("held result changed");

    // a pixel is followed by its histogram update cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_stall |=> pix_stall)
    else $error("pixel accepted during histogram update");

    // a block end is followed by update and check before any new pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_stall && last_pixel |=> ##1 pix_stall)
    else $error("pixel accepted before block check");

    // blocks rejected before the band search carry zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == dhbm_pkg::ST_NO_VALID || status == dhbm_pkg::ST_FEW_VALID)
            |-> mean_depth_mm == '0 && band_index == '0 && band_count == '0)
    else $error("rejected block with non-zero fields");

endmodule

bind depth_histogram_band_mean_unit dhbm_port_checks u_dhbm_port_checks (
    .clk           (clk),
    .rst_n         (rst_n),
    .pix_valid     (pix_valid),
    .pix_stall     (pix_stall),
    .last_pixel    (last_pixel),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .mean_depth_mm (mean_depth_mm),
    .band_index    (band_index),
    .band_count    (band_count),
    .status        (status)
);

// ----- tb/dhbm_checker.sv -----
// dhbm_checker: watches the pixel, result and register channels of the depth
// histogram band mean unit, predicts each block's result and compares it
// depends on dhbm_pkg for widths, status codes and register indexes
`timescale 1ns / 1ps

module dhbm_checker #(
    parameter int BLOCK_PIXELS = 256,
    parameter int BIN_WIDTH    = 500,
    parameter int NUM_BINS     = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pix_valid,
    input  logic                              pix_stall,
    input  logic [dhbm_pkg::DEPTH_W-1:0]      depth_mm,
    input  logic                              last_pixel,
    input  logic                              res_valid,
    input  logic                              res_stall,
    input  logic [dhbm_pkg::DEPTH_W-1:0]      mean_depth_mm,
    input  logic [dhbm_pkg::BAND_W-1:0]       band_index,
    input  logic [dhbm_pkg::COUNT_W-1:0]      band_count,
    input  logic [1:0]                        status,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [dhbm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dhbm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                errors,
    output int                                pending
);

    typedef struct packed {
        logic [dhbm_pkg::DEPTH_W-1:0] mean;
        logic [dhbm_pkg::BAND_W-1:0]  band;
        logic [dhbm_pkg::COUNT_W-1:0] count;
        dhbm_pkg::status_t            st;
    } band_result_t;

    // local copy of the block state and registers
    logic [dhbm_pkg::DEPTH_W-1:0] pix_mem [BLOCK_PIXELS];
    int unsigned        hist [NUM_BINS];
    int unsigned        n_valid;
    int unsigned        n_stored;
    int unsigned        min_valid_q;
    int unsigned        bin_thr_q;

    // scratch for the band search and mean
    int unsigned        band;
    int unsigned        lo;
    int unsigned        hi;
    int unsigned        sum;
    int unsigned        cnt;
    int unsigned        bin;
    int                 k;

    band_result_t       result_q[$];
    band_result_t       want;
    band_result_t       oldest;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_valid_q = dhbm_pkg::MIN_VALID_RST;
            bin_thr_q   = dhbm_pkg::BIN_THRESHOLD_RST;
            for (k = 0; k < NUM_BINS; k++)
                hist[k] = 0;
            n_valid  = 0;
            n_stored = 0;
            result_q.delete();
            errors   = 0;
            pending  = 0;
        end
        else
        begin
            // register writes, unknown indexes are ignored
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == dhbm_pkg::REG_MIN_VALID)
                    min_valid_q = cfg_data;
                else if (cfg_index == dhbm_pkg::REG_BIN_THRESHOLD)
                    bin_thr_q = cfg_data;
            end

            // compare an accepted result item against the oldest prediction
            if (res_valid && !res_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $error("unexpected result item: mean_depth_mm %0d band_index %0d status %0d",
                           mean_depth_mm, band_index, status);
                    errors++;
                end
                else
                begin
                    oldest = result_q.pop_front();
                    if (mean_depth_mm !== oldest.mean)
                    begin
                        $error("mean_depth_mm expected %0d actual %0d", oldest.mean,
                               mean_depth_mm);
                        errors++;
                    end
                    if (band_index !== oldest.band)
                    begin
                        $error("band_index expected %0d actual %0d", oldest.band, band_index);
                        errors++;
                    end
                    if (band_count !== oldest.count)
                    begin
                        $error("band_count expected %0d actual %0d", oldest.count, band_count);
                        errors++;
                    end
                    if (status !== oldest.st)
                    begin
                        $error("status expected %0d actual %0d", oldest.st, status);
                        errors++;
                    end
                end
            end

            // accepted pixel item: store, bin, and on the flag predict the result
            if (pix_valid && !pix_stall)
            begin
                if (n_stored < BLOCK_PIXELS)
                begin
                    pix_mem[n_stored] = depth_mm;
                    n_stored++;
                    bin = depth_mm / BIN_WIDTH;
                    if (bin > NUM_BINS - 1)
                        bin = NUM_BINS - 1;
                    hist[bin]++;
                    if (depth_mm != 0)
                        n_valid++;
                end

                if (last_pixel)
                begin
                    want = '0;
                    if (n_valid == 0)
                        want.st = dhbm_pkg::ST_NO_VALID;
                    else if (n_valid < min_valid_q)
                        want.st = dhbm_pkg::ST_FEW_VALID;
                    else
                    begin
                        // first bin from 1 upward above threshold, else top bin
                        band = NUM_BINS - 1;
                        for (k = NUM_BINS - 1; k >= 1; k--)
                            if (hist[k] > bin_thr_q)
                                band = k;
                        lo  = band * BIN_WIDTH;
                        hi  = (band + 1) * BIN_WIDTH;
                        sum = 0;
                        cnt = 0;
                        for (k = 0; k < n_stored; k++)
                        begin
                            if (pix_mem[k] >= lo && pix_mem[k] <= hi)
                            begin
                                sum += pix_mem[k];
                                cnt++;
                            end
                        end
                        want.band = band[dhbm_pkg::BAND_W-1:0];
                        if (cnt == 0)
                            want.st = dhbm_pkg::ST_EMPTY_BAND;
                        else
                        begin
                            want.st    = dhbm_pkg::ST_OK;
                            want.mean  = dhbm_pkg::DEPTH_W'(sum / cnt);
                            want.count = cnt[dhbm_pkg::COUNT_W-1:0];
                        end
                    end
                    result_q.push_back(want);

                    for (k = 0; k < NUM_BINS; k++)
                        hist[k] = 0;
                    n_valid  = 0;
                    n_stored = 0;
                end
            end

            pending = result_q.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// tb_top: stimulus and verdict for the depth histogram band mean unit
// depends on dhbm_pkg, depth_histogram_band_mean_unit and dhbm_checker
`timescale 1ns / 1ps

module tb_top;

    // register index that decodes to nothing
    localparam logic [dhbm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 4'hF;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            pix_valid = 1'b0;
    logic                            pix_stall;
    logic [dhbm_pkg::DEPTH_W-1:0]    depth_mm = '0;
    logic                            last_pixel = 1'b0;
    logic                            res_valid;
    logic                            res_stall = 1'b0;
    logic [dhbm_pkg::DEPTH_W-1:0]    mean_depth_mm;
    logic [dhbm_pkg::BAND_W-1:0]     band_index;
    logic [dhbm_pkg::COUNT_W-1:0]    band_count;
    logic [1:0]                      status;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [dhbm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [dhbm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    int                    errors;
    int                    pending;
    int                    tx_idle_pct = 17;
    int                    rx_idle_pct = 63;
    logic                  hold_req = 1'b0;
    logic                  held = 1'b0;

    depth_histogram_band_mean_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .pix_valid     (pix_valid),
        .pix_stall     (pix_stall),
        .depth_mm      (depth_mm),
        .last_pixel    (last_pixel),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .mean_depth_mm (mean_depth_mm),
        .band_index    (band_index),
        .band_count    (band_count),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    dhbm_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .pix_valid     (pix_valid),
        .pix_stall     (pix_stall),
        .depth_mm      (depth_mm),
        .last_pixel    (last_pixel),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .mean_depth_mm (mean_depth_mm),
        .band_index    (band_index),
        .band_count    (band_count),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(64'd5_000_000);
        $display("[depth_histogram_band_mean_unit] ERROR");
        $finish;
    end

    // result receiver: random stall, one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                res_stall <= 1'b1;
                repeat (400) @(posedge clk);
            end
            res_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // one pixel item, with random idle cycles ahead of it
    task automatic send_pixel(input logic [dhbm_pkg::DEPTH_W-1:0] d, input logic l);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid  <= 1'b1;
        depth_mm   <= d;
        last_pixel <= l;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
    endtask

    // one register write, then valid is dropped on the channel
    task automatic write_reg(input logic [dhbm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dhbm_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // drain all outstanding results, then let the block settle
    task automatic wait_idle();
        pix_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    // depth near a block center, with zeros, wild values and bin edges mixed in
    function automatic logic [dhbm_pkg::DEPTH_W-1:0] pick_depth(input int center);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        if (r < 25)
            return dhbm_pkg::DEPTH_W'($urandom);
        if (r < 35)
            return dhbm_pkg::DEPTH_W'(int'($urandom_range(0, 17)) * 500
                                      + int'($urandom_range(0, 2)) - 1);
        v = center + int'($urandom_range(0, 600)) - 300;
        if (v < 0)
            v = 0;
        return dhbm_pkg::DEPTH_W'(v);
    endfunction

    task automatic send_block(input int len);
        int center;
        int i;
        center = $urandom_range(0, 8400);
        for (i = 0; i < len; i++)
            send_pixel(pick_depth(center), i == len - 1);
    endtask

    // one setting of the registers, then random blocks up to a pixel budget
    task automatic run_phase(input int mv, input int thr, input int tx, input int rx,
                             input logic pressure, input int budget);
        int used;
        int r;
        int len;
        wait_idle();
        write_reg(dhbm_pkg::REG_MIN_VALID, dhbm_pkg::CFG_DATA_W'(mv));
        write_reg(dhbm_pkg::REG_BIN_THRESHOLD, dhbm_pkg::CFG_DATA_W'(thr));
        tx_idle_pct <= tx;
        rx_idle_pct <= rx;
        if (pressure)
            hold_req <= 1'b1;
        used = 0;
        while (used < budget)
        begin
            r = $urandom_range(0, 99);
            if (r < 1)
                len = $urandom_range(257, 266);
            else if (r < 2)
                len = $urandom_range(100, 256);
            else
                len = $urandom_range(1, 16);
            send_block(len);
            used += len;
        end
    endtask

    // stimulus
    initial
    begin : stimulus
        int i;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: a block with no reading, then one with too few valid
        send_pixel(16'd0, 1'b1);
        send_pixel(16'd1200, 1'b0);
        send_pixel(16'd0, 1'b0);
        send_pixel(16'd3000, 1'b1);

        // lowest threshold, plus a write to an unknown index
        wait_idle();
        write_reg(dhbm_pkg::REG_MIN_VALID, 9'd1);
        write_reg(dhbm_pkg::REG_BIN_THRESHOLD, 9'd0);
        write_reg(REG_UNUSED, 9'h1FF);

        // only bin 0 filled: top bin chosen and nothing lies in it
        send_pixel(16'd100, 1'b0);
        send_pixel(16'd200, 1'b0);
        send_pixel(16'd300, 1'b1);
        // deep pixels saturate into the top bin, only the bound value is averaged
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'd9000, 1'b0);
        send_pixel(16'd8000, 1'b1);
        // inclusive band bounds
        send_pixel(16'd500, 1'b0);
        send_pixel(16'd1000, 1'b0);
        send_pixel(16'd1000, 1'b0);
        send_pixel(16'd750, 1'b1);

        // min_valid equal to the block size with a full block of nonzero pixels in one bin
        wait_idle();
        write_reg(dhbm_pkg::REG_MIN_VALID, 9'd256);
        write_reg(dhbm_pkg::REG_BIN_THRESHOLD, 9'd255);
        for (i = 0; i < 256; i++)
            send_pixel(dhbm_pkg::DEPTH_W'(1000 + $urandom_range(0, 499)), i == 255);

        // overlong block: extra pixels and the flagged one are dropped
        wait_idle();
        write_reg(dhbm_pkg::REG_MIN_VALID, 9'd1);
        write_reg(dhbm_pkg::REG_BIN_THRESHOLD, 9'd3);
        send_block(262);

        // random phases: sender light / receiver heavy, reversed, then no idling
        run_phase(1, 0, 17, 63, 1'b0, 40);
        run_phase(0, 256, 17, 63, 1'b0, 40);
        run_phase($urandom_range(0, 12), $urandom_range(0, 6), 63, 17, 1'b0, 40);
        run_phase(4, 1, 63, 17, 1'b0, 40);
        run_phase($urandom_range(0, 12), $urandom_range(0, 6), 0, 0, 1'b1, 40);
        run_phase($urandom_range(0, 12), $urandom_range(0, 6), 0, 0, 1'b0, 40);

        // drain and settle, then verdict
        wait_idle();
        repeat (400) @(posedge clk);
        @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("[depth_histogram_band_mean_unit] OK");
        else
            $display("[depth_histogram_band_mean_unit] ERROR");
        $finish;
    end

endmodule
